// ===== hw/rtl/u8dec_pkg.sv =====
package u8dec_pkg;

  localparam int BYTE_W   = 8;
  localparam int BITS_W   = 7;
  localparam int CP_W     = 21;
  localparam int LEAST_W  = 17;
  localparam int LEFT_W   = 2;
  localparam int STATUS_W = 2;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_TRUNC   = 2'd2;

  localparam logic [BYTE_W-1:0] ASCII_END  = 8'h80;
  localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hc0;
  localparam logic [BYTE_W-1:0] CONT_MARK  = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD2_LO   = 8'hc2;
  localparam logic [BYTE_W-1:0] LEAD2_HI   = 8'hdf;
  localparam logic [BYTE_W-1:0] LEAD3_LO   = 8'he0;
  localparam logic [BYTE_W-1:0] LEAD3_HI   = 8'hef;
  localparam logic [BYTE_W-1:0] LEAD4_LO   = 8'hf0;
  localparam logic [BYTE_W-1:0] LEAD4_HI   = 8'hf4;
  localparam logic [BYTE_W-1:0] PAYLOAD6   = 8'h3f;

  localparam logic [CP_W-1:0]    MAX_CP    = 21'h10ffff;
  localparam logic [CP_W-1:0]    SURR_LO   = 21'h00d800;
  localparam logic [CP_W-1:0]    SURR_HI   = 21'h00dfff;
  localparam logic [LEAST_W-1:0] LEAST2    = 17'h00080;
  localparam logic [LEAST_W-1:0] LEAST3    = 17'h00800;
  localparam logic [LEAST_W-1:0] LEAST4    = 17'h10000;

  typedef enum logic [2:0] {
    CLS_ASCII,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_CONT,
    CLS_BAD,
    CLS_EOT
  } cls_t;

  // classified request: class plus the payload bits already masked
  typedef struct packed {
    cls_t              cls;
    logic [BITS_W-1:0] bits;
  } entry_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CP_W-1:0]     code_point;
    logic                complete;
  } result_t;

endpackage

// ===== hw/rtl/u8dec_if.sv =====
interface u8dec_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;

  modport source(output valid, output kind, output data_byte, input ready);
  modport sink(input valid, input kind, input data_byte, output ready);
endinterface

interface u8dec_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [20:0] code_point;
  logic        complete;

  modport source(output valid, output status, output code_point, output complete,
                 input ready);
  modport sink(input valid, input status, input code_point, input complete,
               output ready);
endinterface

// ===== hw/rtl/u8dec_front.sv =====
module u8dec_front (
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_kind,
  input  logic [u8dec_pkg::BYTE_W-1:0]   in_byte,
  output logic                           push_valid,
  input  logic                           push_ready,
  output u8dec_pkg::entry_t              push_entry
);

  logic [u8dec_pkg::BYTE_W-1:0] b;

  assign b          = in_byte;
  assign in_ready   = push_ready;
  assign push_valid = in_valid;

  always_comb begin
    push_entry.cls  = u8dec_pkg::CLS_BAD;
    push_entry.bits = '0;
    if (in_kind) begin
      push_entry.cls = u8dec_pkg::CLS_EOT;
    end else if (b < u8dec_pkg::ASCII_END) begin
      push_entry.cls  = u8dec_pkg::CLS_ASCII;
      push_entry.bits = b[6:0];
    end else if ((b & u8dec_pkg::CONT_MASK) == u8dec_pkg::CONT_MARK) begin
      push_entry.cls  = u8dec_pkg::CLS_CONT;
      push_entry.bits = {1'b0, b[5:0]};
    end else if (b >= u8dec_pkg::LEAD2_LO && b <= u8dec_pkg::LEAD2_HI) begin
      push_entry.cls  = u8dec_pkg::CLS_LEAD2;
      push_entry.bits = {2'b0, b[4:0]};
    end else if (b >= u8dec_pkg::LEAD3_LO && b <= u8dec_pkg::LEAD3_HI) begin
      push_entry.cls  = u8dec_pkg::CLS_LEAD3;
      push_entry.bits = {3'b0, b[3:0]};
    end else if (b >= u8dec_pkg::LEAD4_LO && b <= u8dec_pkg::LEAD4_HI) begin
      push_entry.cls  = u8dec_pkg::CLS_LEAD4;
      push_entry.bits = {4'b0, b[2:0]};
    end
  end

endmodule

// ===== hw/rtl/u8dec_queue.sv =====
module u8dec_queue #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  u8dec_pkg::entry_t  push_entry,
  output logic               pop_valid,
  input  logic               pop_ready,
  output u8dec_pkg::entry_t  pop_entry
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  u8dec_pkg::entry_t mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_entry  = mem[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ===== hw/rtl/u8dec_back.sv =====
module u8dec_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  u8dec_pkg::entry_t  pop_entry,
  output logic               out_valid,
  input  logic               out_ready,
  output u8dec_pkg::result_t out_result
);

  logic [u8dec_pkg::CP_W-1:0]    partial_r, partial_nxt;
  logic [u8dec_pkg::LEFT_W-1:0]  left_r, left_nxt;
  logic [u8dec_pkg::LEAST_W-1:0] least_r, least_nxt;
  u8dec_pkg::result_t            res_r, res_nxt;
  logic                          valid_r;
  logic                          pop;
  logic [u8dec_pkg::CP_W-1:0]    v;
  logic [u8dec_pkg::LEFT_W-1:0]  left_dec;
  logic [u8dec_pkg::CP_W-1:0]    least_ext;

  assign pop_ready  = !valid_r || out_ready;
  assign pop        = pop_valid && pop_ready;
  assign out_valid  = valid_r;
  assign out_result = res_r;

  assign v         = {partial_r[u8dec_pkg::CP_W-7:0], pop_entry.bits[5:0]};
  assign left_dec  = left_r - 1'b1;
  assign least_ext = {{(u8dec_pkg::CP_W - u8dec_pkg::LEAST_W){1'b0}}, least_r};

  always_comb begin
    partial_nxt        = partial_r;
    left_nxt           = left_r;
    least_nxt          = least_r;
    res_nxt.status     = u8dec_pkg::STATUS_OK;
    res_nxt.code_point = '0;
    res_nxt.complete   = 1'b0;
    if (pop_entry.cls == u8dec_pkg::CLS_EOT) begin
      if (left_r != '0) begin
        res_nxt.status = u8dec_pkg::STATUS_TRUNC;
      end
    end else if (left_r == '0) begin
      unique case (pop_entry.cls)
        u8dec_pkg::CLS_ASCII: begin
          res_nxt.code_point = {{(u8dec_pkg::CP_W - u8dec_pkg::BITS_W){1'b0}},
                                pop_entry.bits};
          res_nxt.complete   = 1'b1;
        end
        u8dec_pkg::CLS_LEAD2: begin
          partial_nxt = {{(u8dec_pkg::CP_W - 5){1'b0}}, pop_entry.bits[4:0]};
          least_nxt   = u8dec_pkg::LEAST2;
          left_nxt    = 2'd1;
        end
        u8dec_pkg::CLS_LEAD3: begin
          partial_nxt = {{(u8dec_pkg::CP_W - 4){1'b0}}, pop_entry.bits[3:0]};
          least_nxt   = u8dec_pkg::LEAST3;
          left_nxt    = 2'd2;
        end
        u8dec_pkg::CLS_LEAD4: begin
          partial_nxt = {{(u8dec_pkg::CP_W - 3){1'b0}}, pop_entry.bits[2:0]};
          least_nxt   = u8dec_pkg::LEAST4;
          left_nxt    = 2'd3;
        end
        default: begin
          // stray continuation or illegal lead: stay idle
          res_nxt.status = u8dec_pkg::STATUS_INVALID;
        end
      endcase
    end else if (pop_entry.cls != u8dec_pkg::CLS_CONT) begin
      // drop the byte and abandon the open sequence
      partial_nxt    = '0;
      left_nxt       = '0;
      least_nxt      = '0;
      res_nxt.status = u8dec_pkg::STATUS_INVALID;
    end else if (left_dec != '0) begin
      partial_nxt = v;
      left_nxt    = left_dec;
    end else begin
      partial_nxt = '0;
      left_nxt    = '0;
      least_nxt   = '0;
      if (v < least_ext || v > u8dec_pkg::MAX_CP ||
          (v >= u8dec_pkg::SURR_LO && v <= u8dec_pkg::SURR_HI)) begin
        res_nxt.status = u8dec_pkg::STATUS_INVALID;
      end else begin
        res_nxt.code_point = v;
        res_nxt.complete   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      left_r    <= '0;
      least_r   <= '0;
      valid_r   <= 1'b0;
    end else begin
      if (pop) begin
        partial_r <= partial_nxt;
        left_r    <= left_nxt;
        least_r   <= least_nxt;
        valid_r   <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
  end

endmodule

// ===== hw/rtl/utf8_strict_decoder.sv =====
// Channel  Dir  Handshake          Payload
// in_ch    in   valid/ready        kind, data_byte
// out_ch   out  valid/ready        status, code_point, complete
//
// One byte per cycle sustained while out_ch does not stall, a rate set by the
// back end's update; each request yields one result via the queue and res_r.
// Reset clears the decode state, empties the queue and drops any pending result.
// While out_ch stalls, up to QUEUE_DEPTH requests collect in the queue before
// in_ch.ready falls.
module utf8_strict_decoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  u8dec_in_if.sink      in_ch,
  u8dec_out_if.source   out_ch
);

  logic               push_valid, push_ready;
  u8dec_pkg::entry_t  push_entry;
  logic               pop_valid, pop_ready;
  u8dec_pkg::entry_t  pop_entry;
  logic               res_valid;
  u8dec_pkg::result_t res;

  u8dec_front u_front (
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_kind    (in_ch.kind),
    .in_byte    (in_ch.data_byte),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  u8dec_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  u8dec_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry),
    .out_valid  (res_valid),
    .out_ready  (out_ch.ready),
    .out_result (res)
  );

  assign out_ch.valid      = res_valid;
  assign out_ch.status     = res.status;
  assign out_ch.code_point = res.code_point;
  assign out_ch.complete   = res.complete;

endmodule

// ===== bench/tb_utf8_strict_decoder.sv =====
`timescale 1ns / 100ps

module tb_utf8_strict_decoder;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_EOT  = 1'b1;

  localparam int CYCLE_LIMIT    = 200000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int ITEMS_PER_PHASE = 440;

  logic clk;
  logic rst_n;

  u8dec_in_if  in_ch();
  u8dec_out_if out_ch();

  utf8_strict_decoder i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // decoder state as predicted from the accepted requests
  logic [u8dec_pkg::CP_W-1:0]    acc_cp;
  logic [u8dec_pkg::LEFT_W-1:0]  cont_due;
  logic [u8dec_pkg::LEAST_W-1:0] floor_cp;

  u8dec_pkg::result_t pending_results[$];
  u8dec_pkg::result_t want_res;

  int send_idle_pct;
  int stall_pct;
  int cycle_cnt;
  int n_requests;
  int n_results;
  int n_bad;
  int n_complete;
  int n_invalid;
  int n_trunc;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic u8dec_pkg::result_t predict_decode(logic k,
                                                        logic [u8dec_pkg::BYTE_W-1:0] b);
    u8dec_pkg::result_t r;
    logic [u8dec_pkg::CP_W-1:0] v;
    r = '0;
    r.status = u8dec_pkg::STATUS_OK;
    if (k == KIND_EOT) begin
      // end of text leaves the open sequence alone
      r.status = (cont_due != '0) ? u8dec_pkg::STATUS_TRUNC : u8dec_pkg::STATUS_OK;
      return r;
    end
    if (cont_due == '0) begin
      if (b < u8dec_pkg::ASCII_END) begin
        r.code_point = u8dec_pkg::CP_W'(b);
        r.complete   = 1'b1;
      end else if (b >= u8dec_pkg::LEAD2_LO && b <= u8dec_pkg::LEAD2_HI) begin
        acc_cp   = u8dec_pkg::CP_W'(b[4:0]);
        floor_cp = u8dec_pkg::LEAST2;
        cont_due = 2'd1;
      end else if (b >= u8dec_pkg::LEAD3_LO && b <= u8dec_pkg::LEAD3_HI) begin
        acc_cp   = u8dec_pkg::CP_W'(b[3:0]);
        floor_cp = u8dec_pkg::LEAST3;
        cont_due = 2'd2;
      end else if (b >= u8dec_pkg::LEAD4_LO && b <= u8dec_pkg::LEAD4_HI) begin
        acc_cp   = u8dec_pkg::CP_W'(b[2:0]);
        floor_cp = u8dec_pkg::LEAST4;
        cont_due = 2'd3;
      end else begin
        r.status = u8dec_pkg::STATUS_INVALID;
      end
    end else if ((b & u8dec_pkg::CONT_MASK) != u8dec_pkg::CONT_MARK) begin
      // drop the byte, do not restart on it
      acc_cp   = '0;
      floor_cp = '0;
      cont_due = '0;
      r.status = u8dec_pkg::STATUS_INVALID;
    end else begin
      acc_cp   = {acc_cp[u8dec_pkg::CP_W-7:0], b[5:0]};
      cont_due = cont_due - 2'd1;
      if (cont_due == '0) begin
        v = acc_cp;
        if (v < u8dec_pkg::CP_W'(floor_cp) || v > u8dec_pkg::MAX_CP ||
            (v >= u8dec_pkg::SURR_LO && v <= u8dec_pkg::SURR_HI)) begin
          r.status = u8dec_pkg::STATUS_INVALID;
        end else begin
          r.code_point = v;
          r.complete   = 1'b1;
        end
        acc_cp   = '0;
        floor_cp = '0;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               pending_results.size());
      $display("tb_utf8_strict_decoder: done, errors");
      $finish;
    end
  end

  // predict on each accepted request first, so a same-edge result still finds it
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        pending_results.push_back(predict_decode(in_ch.kind, in_ch.data_byte));
        n_requests++;
      end
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (pending_results.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("unexpected result: status=%0d cp=%06h complete=%0d",
                     out_ch.status, out_ch.code_point, out_ch.complete);
        end else begin
          want_res = pending_results.pop_front();
          if (out_ch.status !== want_res.status ||
              out_ch.code_point !== want_res.code_point ||
              out_ch.complete !== want_res.complete) begin
            n_bad++;
            if (n_bad <= 10)
              $display("mismatch at result %0d: expected status=%0d cp=%06h complete=%0d, %s",
                       n_results, want_res.status, want_res.code_point, want_res.complete,
                       $sformatf("got status=%0d cp=%06h complete=%0d",
                                 out_ch.status, out_ch.code_point, out_ch.complete));
          end else begin
            if (want_res.complete) n_complete++;
            if (want_res.status == u8dec_pkg::STATUS_INVALID) n_invalid++;
            if (want_res.status == u8dec_pkg::STATUS_TRUNC) n_trunc++;
          end
        end
      end
    end
  end

  // hold valid across back-to-back requests, drop it only for an idle gap
  task automatic send_request(input logic k, input logic [u8dec_pkg::BYTE_W-1:0] b);
    int gap;
    gap = 0;
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct && gap < 60)
      gap++;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.kind      <= k;
    in_ch.data_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic test_single_bytes();
    send_request(KIND_DATA, 8'h00);
    send_request(KIND_DATA, 8'h7f);
    send_request(KIND_EOT,  8'hff);
    // bytes that can never start a sequence
    send_request(KIND_DATA, 8'h80);
    send_request(KIND_DATA, 8'hc1);
    send_request(KIND_DATA, 8'hff);
  endtask

  task automatic test_multibyte_valid();
    send_request(KIND_DATA, 8'hc2);
    send_request(KIND_DATA, 8'h80);
    // highest scalar value
    send_request(KIND_DATA, 8'hf4);
    send_request(KIND_DATA, 8'h8f);
    send_request(KIND_DATA, 8'hbf);
    send_request(KIND_DATA, 8'hbf);
  endtask

  task automatic test_rejected_values();
    // overlong three-byte form
    send_request(KIND_DATA, 8'he0);
    send_request(KIND_DATA, 8'h9f);
    send_request(KIND_DATA, 8'hbf);
    // surrogate
    send_request(KIND_DATA, 8'hed);
    send_request(KIND_DATA, 8'ha0);
    send_request(KIND_DATA, 8'h80);
    // just above the scalar range
    send_request(KIND_DATA, 8'hf4);
    send_request(KIND_DATA, 8'h90);
    send_request(KIND_DATA, 8'h80);
    send_request(KIND_DATA, 8'h80);
  endtask

  task automatic test_broken_sequences();
    // missing continuation: the ASCII byte is swallowed
    send_request(KIND_DATA, 8'hc2);
    send_request(KIND_DATA, 8'h41);
    // end of text inside a sequence, then finish it
    send_request(KIND_DATA, 8'he2);
    send_request(KIND_EOT,  8'h00);
    send_request(KIND_DATA, 8'h82);
    send_request(KIND_DATA, 8'hac);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall, input int n_items);
    int sent;
    int pick;
    int len;
    int keep;
    logic [u8dec_pkg::BYTE_W-1:0] lead;
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    sent          = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        len = $urandom_range(1, 4);
        case (len)
          1:       lead = u8dec_pkg::BYTE_W'($urandom_range(0, 127));
          2:       lead = u8dec_pkg::BYTE_W'($urandom_range(u8dec_pkg::LEAD2_LO,
                                                            u8dec_pkg::LEAD2_HI));
          3:       lead = u8dec_pkg::BYTE_W'($urandom_range(u8dec_pkg::LEAD3_LO,
                                                            u8dec_pkg::LEAD3_HI));
          default: lead = u8dec_pkg::BYTE_W'($urandom_range(u8dec_pkg::LEAD4_LO,
                                                            u8dec_pkg::LEAD4_HI));
        endcase
        // a share of sequences is cut short and runs into whatever follows
        keep = (pick < 55) ? len : $urandom_range(1, len);
        send_request(KIND_DATA, lead);
        sent++;
        for (int i = 1; i < keep; i++) begin
          send_request(KIND_DATA,
                       u8dec_pkg::CONT_MARK | u8dec_pkg::BYTE_W'($urandom_range(0, 63)));
          sent++;
        end
      end else if (pick < 77) begin
        send_request(KIND_EOT, u8dec_pkg::BYTE_W'($urandom_range(0, 255)));
        sent++;
      end else begin
        send_request(KIND_DATA, u8dec_pkg::BYTE_W'($urandom_range(0, 255)));
        sent++;
      end
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.kind       = KIND_DATA;
    in_ch.data_byte  = '0;
    out_ch.ready     = 1'b0;
    acc_cp           = '0;
    cont_due         = '0;
    floor_cp         = '0;
    send_idle_pct    = 0;
    stall_pct        = 0;
    cycle_cnt        = 0;
    n_requests       = 0;
    n_results        = 0;
    n_bad            = 0;
    n_complete       = 0;
    n_invalid        = 0;
    n_trunc          = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_single_bytes();
    test_multibyte_valid();
    test_rejected_values();
    test_broken_sequences();

    test_random_traffic(0,  0,  ITEMS_PER_PHASE);
    test_random_traffic(86, 0,  ITEMS_PER_PHASE);
    test_random_traffic(0,  86, ITEMS_PER_PHASE);
    test_random_traffic(31, 31, ITEMS_PER_PHASE);

    in_ch.valid <= 1'b0;
    stall_pct   = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d bytes and end-of-text marks over four handshake mixes, %0d results back",
             n_requests, n_results);
    $display("decoded %0d code points, %0d rejected, %0d truncations, %0d mismatches",
             n_complete, n_invalid, n_trunc, n_bad);
    if (n_bad == 0 && pending_results.size() == 0) begin
      $display("tb_utf8_strict_decoder: done, clean");
    end else begin
      $display("tb_utf8_strict_decoder: done, errors");
    end
    $finish;
  end

endmodule
